FILE: rtl/assert_macros.svh
// Assertion macros shared by the convolution RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define IC2D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define IC2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IC2D_ASSERT(lbl, clk, rst_n, prop, msg)
`define IC2D_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/ic2d_pkg.sv
// Package of the 2D convolution block: sizes, field widths, codes and the
// structs passed between its modules. Depends on nothing.
package ic2d_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_KW     = 7;
  localparam int MAX_KH     = 7;

  localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KER_DEPTH = MAX_KW * MAX_KH;
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  localparam int KC_W      = $clog2(MAX_KW + 1);
  localparam int KR_W      = $clog2(MAX_KH + 1);

  // Field widths fixed by the item format.
  localparam int OP_W    = 2;
  localparam int XY_W    = 8;
  localparam int PIX_W   = 16;
  localparam int RES_W   = 32;
  localparam int DIM_W   = 9;
  localparam int KDIM_W  = 3;
  localparam int COORD_W = 11;

  localparam int PROD_W = 2 * PIX_W;
  localparam int ACC_W  = PROD_W + KER_AW + 1;
  localparam int FRAC_W = 14;
  localparam int Q_W    = ACC_W - FRAC_W;

  localparam int APB_DW  = 32;
  localparam int PADDR_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_PIXEL = 2'd0,
    OP_WRITE_COEF  = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_KERNEL_WIDTH  = 2'd2,
    REG_KERNEL_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } seq_state_e;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [XY_W-1:0]         col;
    logic [XY_W-1:0]         row;
    logic signed [PIX_W-1:0] value;
  } in_item_t;

  // Effective sizes after clamping and odd rounding.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [KDIM_W-1:0] kw;
    logic [KDIM_W-1:0] kh;
    logic [KDIM_W-1:0] hw;
    logic [KDIM_W-1:0] hh;
  } cfg_eff_t;

  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic load;
    logic load_compute;
  } mac_ctrl_t;

  typedef struct packed {
    logic slot_free;
  } mac_stat_t;

endpackage

FILE: rtl/ic2d_if.sv
// Stream interfaces of the convolution block: the item channel and the
// result channel. Depends on ic2d_pkg for the field widths.
interface ic2d_in_if;
  logic                             valid;
  logic                             ready;
  logic [ic2d_pkg::OP_W-1:0]        operation;
  logic [ic2d_pkg::XY_W-1:0]        col;
  logic [ic2d_pkg::XY_W-1:0]        row;
  logic signed [ic2d_pkg::PIX_W-1:0] value;

  modport source (output valid, operation, col, row, value, input ready);
  modport sink (input valid, operation, col, row, value, output ready);
endinterface

interface ic2d_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ic2d_pkg::RES_W-1:0] result;
  logic                              saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink (input valid, result, saturated, output ready);
endinterface

FILE: rtl/ic2d_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module ic2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/ic2d_cfg.sv
// APB register bank of the convolution block and the derived effective
// sizes. Depends on ic2d_pkg.
module ic2d_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ic2d_pkg::PADDR_W-1:0]  paddr,
  input  logic [ic2d_pkg::APB_DW-1:0]   pwdata,
  output logic [ic2d_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output ic2d_pkg::cfg_eff_t            cfg_o
);

  logic [ic2d_pkg::DIM_W-1:0]  iw_q, ih_q;
  logic [ic2d_pkg::KDIM_W-1:0] kw_q, kh_q;
  logic [1:0]                  reg_idx;
  logic                        wr_en;

  function automatic logic [ic2d_pkg::DIM_W-1:0] clamp_dim(
    input logic [ic2d_pkg::DIM_W-1:0] v, input int hi);
    logic [ic2d_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ic2d_pkg::DIM_W'(1);
    end else if (int'(v) > hi) begin
      r = ic2d_pkg::DIM_W'(hi);
    end
    return r;
  endfunction

  function automatic logic [ic2d_pkg::KDIM_W-1:0] odd_dim(
    input logic [ic2d_pkg::KDIM_W-1:0] v, input int hi);
    logic [ic2d_pkg::KDIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ic2d_pkg::KDIM_W'(1);
    end else if (int'(v) > hi) begin
      r = ic2d_pkg::KDIM_W'(hi);
    end
    if (!r[0]) begin
      r = r - ic2d_pkg::KDIM_W'(1);
    end
    return r;
  endfunction

  assign reg_idx = paddr[ic2d_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= ic2d_pkg::DIM_W'(256);
      ih_q <= ic2d_pkg::DIM_W'(256);
      kw_q <= ic2d_pkg::KDIM_W'(3);
      kh_q <= ic2d_pkg::KDIM_W'(3);
    end else if (wr_en) begin
      case (reg_idx)
        ic2d_pkg::REG_IMAGE_WIDTH:   iw_q <= pwdata[ic2d_pkg::DIM_W-1:0];
        ic2d_pkg::REG_IMAGE_HEIGHT:  ih_q <= pwdata[ic2d_pkg::DIM_W-1:0];
        ic2d_pkg::REG_KERNEL_WIDTH:  kw_q <= pwdata[ic2d_pkg::KDIM_W-1:0];
        ic2d_pkg::REG_KERNEL_HEIGHT: kh_q <= pwdata[ic2d_pkg::KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ic2d_pkg::REG_IMAGE_WIDTH:   prdata = ic2d_pkg::APB_DW'(iw_q);
      ic2d_pkg::REG_IMAGE_HEIGHT:  prdata = ic2d_pkg::APB_DW'(ih_q);
      ic2d_pkg::REG_KERNEL_WIDTH:  prdata = ic2d_pkg::APB_DW'(kw_q);
      ic2d_pkg::REG_KERNEL_HEIGHT: prdata = ic2d_pkg::APB_DW'(kh_q);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.w  = clamp_dim(iw_q, ic2d_pkg::MAX_WIDTH);
    cfg_o.h  = clamp_dim(ih_q, ic2d_pkg::MAX_HEIGHT);
    cfg_o.kw = odd_dim(kw_q, ic2d_pkg::MAX_KW);
    cfg_o.kh = odd_dim(kh_q, ic2d_pkg::MAX_KH);
    cfg_o.hw = cfg_o.kw >> 1;
    cfg_o.hh = cfg_o.kh >> 1;
  end

endmodule

FILE: rtl/ic2d_seq.sv
// Sequencer of the convolution block: takes items, writes the stores and
// walks the kernel taps through the memories. Depends on ic2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ic2d_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ic2d_pkg::in_item_t            in_item_i,
  output logic                          in_ready_o,
  input  ic2d_pkg::cfg_eff_t            cfg_i,
  input  ic2d_pkg::mac_stat_t           stat_i,
  output ic2d_pkg::mac_ctrl_t           ctrl_o,
  output logic                          img_we_o,
  output logic [ic2d_pkg::IMG_AW-1:0]   img_waddr_o,
  output logic [ic2d_pkg::IMG_AW-1:0]   img_raddr_o,
  output logic                          ker_we_o,
  output logic [ic2d_pkg::KER_AW-1:0]   ker_waddr_o,
  output logic [ic2d_pkg::KER_AW-1:0]   ker_raddr_o
);

  ic2d_pkg::seq_state_e state_q, state_d;

  logic [ic2d_pkg::KC_W-1:0] kc_q, kc_d;
  logic [ic2d_pkg::KR_W-1:0] kr_q, kr_d;
  logic                      drain_q, drain_d;
  logic [ic2d_pkg::XY_W-1:0] x_q, x_d, y_q, y_d;
  logic                      cmp_q, cmp_d;

  logic signed [ic2d_pkg::COORD_W-1:0] sx, sy;
  logic [ic2d_pkg::COORD_W-1:0]        sx_u, sy_u;
  logic                                tap_in, last_col, last_row, accept;

  assign accept = in_valid_i && in_ready_o;

  // Source pixel of the current tap: (x + hw - kc, y + hh - kr).
  assign sx = ic2d_pkg::COORD_W'(x_q) + ic2d_pkg::COORD_W'(cfg_i.hw)
              - ic2d_pkg::COORD_W'(kc_q);
  assign sy = ic2d_pkg::COORD_W'(y_q) + ic2d_pkg::COORD_W'(cfg_i.hh)
              - ic2d_pkg::COORD_W'(kr_q);
  assign sx_u = sx;
  assign sy_u = sy;
  assign tap_in = (sx >= 0) && (sx < $signed(ic2d_pkg::COORD_W'(cfg_i.w)))
               && (sy >= 0) && (sy < $signed(ic2d_pkg::COORD_W'(cfg_i.h)));

  assign last_col = (kc_q == ic2d_pkg::KC_W'(cfg_i.kw - ic2d_pkg::KDIM_W'(1)));
  assign last_row = (kr_q == ic2d_pkg::KR_W'(cfg_i.kh - ic2d_pkg::KDIM_W'(1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ic2d_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.operation == ic2d_pkg::OP_COMPUTE) begin
            state_d = ic2d_pkg::ST_ISSUE;
          end else begin
            state_d = ic2d_pkg::ST_RESULT;
          end
        end
      end
      ic2d_pkg::ST_ISSUE: begin
        if (last_col && last_row) begin
          state_d = ic2d_pkg::ST_DRAIN;
        end
      end
      ic2d_pkg::ST_DRAIN: begin
        if (drain_q) begin
          state_d = ic2d_pkg::ST_RESULT;
        end
      end
      ic2d_pkg::ST_RESULT: begin
        if (stat_i.slot_free) begin
          state_d = ic2d_pkg::ST_IDLE;
        end
      end
      default: state_d = ic2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    ctrl_o       = '0;
    img_we_o     = 1'b0;
    ker_we_o     = 1'b0;
    img_waddr_o  = ic2d_pkg::IMG_AW'(32'(in_item_i.row) * ic2d_pkg::MAX_WIDTH
                                     + 32'(in_item_i.col));
    ker_waddr_o  = ic2d_pkg::KER_AW'(32'(in_item_i.row) * ic2d_pkg::MAX_KW
                                     + 32'(in_item_i.col));
    img_raddr_o  = ic2d_pkg::IMG_AW'(32'(sy_u) * ic2d_pkg::MAX_WIDTH + 32'(sx_u));
    ker_raddr_o  = ic2d_pkg::KER_AW'(32'(kr_q) * ic2d_pkg::MAX_KW + 32'(kc_q));
    kc_d         = kc_q;
    kr_d         = kr_q;
    drain_d      = 1'b0;
    x_d          = x_q;
    y_d          = y_q;
    cmp_d        = cmp_q;
    case (state_q)
      ic2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d   = in_item_i.col;
          y_d   = in_item_i.row;
          kc_d  = '0;
          kr_d  = '0;
          cmp_d = 1'b0;
          case (in_item_i.operation)
            ic2d_pkg::OP_WRITE_PIXEL: begin
              img_we_o = (32'(in_item_i.col) < ic2d_pkg::MAX_WIDTH)
                      && (32'(in_item_i.row) < ic2d_pkg::MAX_HEIGHT);
            end
            ic2d_pkg::OP_WRITE_COEF: begin
              ker_we_o = (32'(in_item_i.col) < ic2d_pkg::MAX_KW)
                      && (32'(in_item_i.row) < ic2d_pkg::MAX_KH);
            end
            ic2d_pkg::OP_COMPUTE: begin
              cmp_d        = 1'b1;
              ctrl_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ic2d_pkg::ST_ISSUE: begin
        ctrl_o.tap_valid = tap_in;
        if (last_col) begin
          kc_d = '0;
          kr_d = kr_q + ic2d_pkg::KR_W'(1);
        end else begin
          kc_d = kc_q + ic2d_pkg::KC_W'(1);
        end
      end
      ic2d_pkg::ST_DRAIN: begin
        drain_d = !drain_q;
      end
      ic2d_pkg::ST_RESULT: begin
        ctrl_o.load         = stat_i.slot_free;
        ctrl_o.load_compute = cmp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ic2d_pkg::ST_IDLE;
      kc_q    <= '0;
      kr_q    <= '0;
      drain_q <= 1'b0;
      cmp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kc_q    <= kc_d;
      kr_q    <= kr_d;
      drain_q <= drain_d;
      cmp_q   <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  `IC2D_ASSERT_ALWAYS(a_load_needs_slot, clk_i, ctrl_o.load |-> stat_i.slot_free, "result loaded into a full output slot")
  `IC2D_ASSERT(a_issue_to_drain, clk_i, rst_ni, state_q == ic2d_pkg::ST_ISSUE |=> (state_q == ic2d_pkg::ST_ISSUE || state_q == ic2d_pkg::ST_DRAIN), "tap walk left without draining")
  `IC2D_ASSERT_ALWAYS(a_store_write_on_accept, clk_i, (img_we_o || ker_we_o) |-> accept, "store written without an accepted transaction")

endmodule

FILE: rtl/ic2d_mac.sv
// Shared multiply-accumulate of the convolution block, result rounding and
// saturation, and the output register. Depends on ic2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ic2d_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ic2d_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [ic2d_pkg::PIX_W-1:0] pix_i,
  input  logic signed [ic2d_pkg::PIX_W-1:0] coef_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [ic2d_pkg::RES_W-1:0] result_o,
  output logic                              saturated_o,
  output ic2d_pkg::mac_stat_t               stat_o
);

  localparam logic signed [63:0] ResMax = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] ResMin = -64'sh0000_0000_8000_0000;

  logic                               v1_q, v2_q;
  logic signed [ic2d_pkg::PROD_W-1:0] prod_q;
  logic signed [ic2d_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [ic2d_pkg::Q_W-1:0]    q;
  logic signed [63:0]                 q_ext;
  logic signed [ic2d_pkg::RES_W-1:0]  res;
  logic                               sat;
  logic                               out_valid_q;

  // The sum is Q.14; an arithmetic shift rounds toward minus infinity.
  assign q     = ic2d_pkg::Q_W'(acc_q >>> ic2d_pkg::FRAC_W);
  assign q_ext = 64'(q);

  always_comb begin
    sat = 1'b0;
    res = q_ext[ic2d_pkg::RES_W-1:0];
    if (q_ext > ResMax) begin
      res = ResMax[ic2d_pkg::RES_W-1:0];
      sat = 1'b1;
    end else if (q_ext < ResMin) begin
      res = ResMin[ic2d_pkg::RES_W-1:0];
      sat = 1'b1;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + ic2d_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.tap_valid;
      v2_q <= v1_q;
      if (ctrl_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_i * coef_i;
    acc_q  <= acc_d;
    if (ctrl_i.load) begin
      result_o    <= ctrl_i.load_compute ? res : '0;
      saturated_o <= ctrl_i.load_compute && sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

  `IC2D_ASSERT(a_load_after_drain, clk_i, rst_ni, (ctrl_i.load && ctrl_i.load_compute) |-> (!v1_q && !v2_q), "result taken while taps are in flight")
  `IC2D_ASSERT(a_clear_when_empty, clk_i, rst_ni, ctrl_i.clear |-> (!v1_q && !v2_q && !ctrl_i.tap_valid), "accumulator cleared while taps are in flight")

endmodule

FILE: rtl/image_convolution_2d.sv
// Top level of the 2D convolution block with zero padding at the borders.
// Depends on ic2d_pkg, ic2d_if, ic2d_ram, ic2d_cfg, ic2d_seq and ic2d_mac.
//
//   channel   direction  handshake       payload
//   in_i      sink       valid / ready   operation, col, row, value
//   out_o     source     valid / ready   result, saturated
//   APB       slave      psel / penable  paddr, pwdata, prdata (pready high)
//
// In the transaction cycle a pixel or coefficient write goes into its store;
// such a write or an unused operation then loads the result register. A
// compute walks the kw*kh taps through the single multiply-accumulate, which
// takes one tap per cycle from the image memory read port, then drains and
// loads the result register. The stores have no reset and no clearing pass.
// A new transaction is taken while the previous result still waits; the
// sequencer holds that item in its result state until the output slot frees.
module image_convolution_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ic2d_in_if.sink                       in_i,
  ic2d_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ic2d_pkg::PADDR_W-1:0]  paddr,
  input  logic [ic2d_pkg::APB_DW-1:0]   pwdata,
  output logic [ic2d_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  ic2d_pkg::cfg_eff_t  cfg;
  ic2d_pkg::mac_ctrl_t ctrl;
  ic2d_pkg::mac_stat_t stat;
  ic2d_pkg::in_item_t  item;

  logic                          img_we, ker_we;
  logic [ic2d_pkg::IMG_AW-1:0]   img_waddr, img_raddr;
  logic [ic2d_pkg::KER_AW-1:0]   ker_waddr, ker_raddr;
  logic [ic2d_pkg::PIX_W-1:0]    img_rdata, ker_rdata;

  // Pack the item channel payload for the sequencer.
  assign item.operation = in_i.operation;
  assign item.col       = in_i.col;
  assign item.row       = in_i.row;
  assign item.value     = in_i.value;

  // Configuration registers; sizes are clamped and kernel sizes forced odd.
  ic2d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer owns both memory ports: writes happen in the transaction
  // cycle, reads only during the tap walk, so the two never overlap.
  ic2d_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (item),
    .in_ready_o  (in_i.ready),
    .cfg_i       (cfg),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .img_we_o    (img_we),
    .img_waddr_o (img_waddr),
    .img_raddr_o (img_raddr),
    .ker_we_o    (ker_we),
    .ker_waddr_o (ker_waddr),
    .ker_raddr_o (ker_raddr)
  );

  // Image store, addressed row * MAX_WIDTH + col.
  ic2d_ram #(
    .Width (ic2d_pkg::PIX_W),
    .Depth (ic2d_pkg::IMG_DEPTH)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (item.value),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  // Kernel store, addressed row * MAX_KW + col.
  ic2d_ram #(
    .Width (ic2d_pkg::PIX_W),
    .Depth (ic2d_pkg::KER_DEPTH)
  ) u_ker_ram (
    .clk_i   (clk_i),
    .we_i    (ker_we),
    .waddr_i (ker_waddr),
    .wdata_i (item.value),
    .raddr_i (ker_raddr),
    .rdata_o (ker_rdata)
  );

  // Multiply, accumulate and the output register that drives out_o.
  ic2d_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pix_i       ($signed(img_rdata)),
    .coef_i      ($signed(ker_rdata)),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (out_o.result),
    .saturated_o (out_o.saturated),
    .stat_o      (stat)
  );

endmodule

FILE: dv/image_convolution_2d_tb.sv
// Self-checking testbench of image_convolution_2d: pixel and coefficient writes,
// zero-padded convolution at random coordinates and several size settings.
// Depends on ic2d_pkg, the ic2d_in_if / ic2d_out_if interfaces and the RTL.
module image_convolution_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ic2d_pkg::*;

  // Operation 3 has no member in the package enum; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
  localparam int SETTLE_CYCLES  = 8;     // quiet cycles before a register write
  localparam int TAIL_CYCLES    = 60;    // a bit more than one 7x7 compute
  localparam int LONG_HOLD      = 300;   // output stall that backs up the input
  localparam int NUM_PHASES     = 12;

  localparam longint RES_MAX = 64'sd2147483647;
  localparam longint RES_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [RES_W-1:0] result;
    logic                    saturated;
  } conv_out_t;

  // Holds a private copy of both stores and the size registers, computes the
  // expected output for every accepted transaction and checks the outputs in
  // order against it.
  class conv_checker;
    logic signed [PIX_W-1:0] pixel_mem [IMG_DEPTH];
    logic signed [PIX_W-1:0] coef_mem [KER_DEPTH];
    logic [DIM_W-1:0]        img_w, img_h;
    logic [KDIM_W-1:0]       ker_w, ker_h;
    conv_out_t               conv_out_q[$];
    int                      errors;
    int                      outputs_seen;
    int                      computes_seen;

    function new();
      img_w = 9'd256;
      img_h = 9'd256;
      ker_w = 3'd3;
      ker_h = 3'd3;
    endfunction

    function void set_register(reg_idx_e idx, logic [APB_DW-1:0] word);
      case (idx)
        REG_IMAGE_WIDTH:   img_w = word[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  img_h = word[DIM_W-1:0];
        REG_KERNEL_WIDTH:  ker_w = word[KDIM_W-1:0];
        REG_KERNEL_HEIGHT: ker_h = word[KDIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int fit_size(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Effective image size and kernel half-sizes; even kernel sizes drop to
    // the next lower odd value.
    function void window(output int w, output int h, output int hw, output int hh);
      int kw, kh;
      w  = fit_size(int'(img_w), MAX_WIDTH);
      h  = fit_size(int'(img_h), MAX_HEIGHT);
      kw = fit_size(int'(ker_w), MAX_KW);
      kh = fit_size(int'(ker_h), MAX_KH);
      if (kw % 2 == 0) kw--;
      if (kh % 2 == 0) kh--;
      hw = kw / 2;
      hh = kh / 2;
    endfunction

    function void note_item(in_item_t it);
      conv_out_t want;
      int        w, h, hw, hh, x, y, sx, sy;
      longint    acc, q;
      want.result    = '0;
      want.saturated = 1'b0;
      x = int'(it.col);
      y = int'(it.row);
      case (it.operation)
        OP_WRITE_PIXEL: begin
          if (x < MAX_WIDTH && y < MAX_HEIGHT) pixel_mem[y * MAX_WIDTH + x] = it.value;
        end
        OP_WRITE_COEF: begin
          if (x < MAX_KW && y < MAX_KH) coef_mem[y * MAX_KW + x] = it.value;
        end
        OP_COMPUTE: begin
          computes_seen++;
          window(w, h, hw, hh);
          acc = 0;
          // True convolution: tap (i, j) takes the pixel at (x-i, y-j); taps
          // that fall off the image contribute nothing.
          for (int j = -hh; j <= hh; j++) begin
            for (int i = -hw; i <= hw; i++) begin
              sx = x - i;
              sy = y - j;
              if (sx >= 0 && sy >= 0 && sx < w && sy < h)
                acc += longint'(pixel_mem[sy * MAX_WIDTH + sx]) *
                       longint'(coef_mem[(j + hh) * MAX_KW + (i + hw)]);
            end
          end
          // Arithmetic shift floors, which is the rounding the block uses.
          q = acc >>> FRAC_W;
          // With 16-bit pixels and at most 49 taps the clip cannot trigger,
          // but the flag is predicted the same way regardless.
          if (q > RES_MAX) begin
            q = RES_MAX;
            want.saturated = 1'b1;
          end
          if (q < RES_MIN) begin
            q = RES_MIN;
            want.saturated = 1'b1;
          end
          want.result = q[RES_W-1:0];
        end
        default: ;
      endcase
      conv_out_q.push_back(want);
    endfunction

    function void check_pixel_out(logic signed [RES_W-1:0] result, logic saturated);
      conv_out_t want;
      outputs_seen++;
      if (conv_out_q.size() == 0) begin
        $error("output transaction with nothing expected: result %0d", result);
        errors++;
        return;
      end
      want = conv_out_q.pop_front();
      if (result !== want.result) begin
        $error("result: expected %0d, actual %0d", want.result, result);
        errors++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
        errors++;
      end
    endfunction

    function int pending();
      return conv_out_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ic2d_in_if  in_bus ();
  ic2d_out_if out_bus ();

  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  image_convolution_2d uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  conv_checker chk = new();

  // The stimulus tracks which store entries hold a value, so that a compute
  // never reaches a pixel or coefficient that was never written.
  bit pix_set [IMG_DEPTH];
  bit coef_set [KER_DEPTH];

  bit src_throttle;
  bit snk_throttle;
  int hold_req;
  bit held_once;
  int sent_items;
  int quiet_cycles = 0;

  // Both monitors sample at the rising edge, before any of this edge's
  // nonblocking updates land, so they see exactly what the block sees.
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      chk.note_item('{in_bus.operation, in_bus.col, in_bus.row, in_bus.value});
    if (rst_ni && out_bus.valid && out_bus.ready)
      chk.check_pixel_out(out_bus.result, out_bus.saturated);
  end

  // Watchdog: any transaction on either stream or on the register port counts
  // as progress.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $error("no transaction for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, chk.pending());
    $display("** image_convolution_2d: FAILED **");
    $finish;
  end

  // Output side: random stall bursts while throttling is on, plus one long
  // hold-off on request that lets the block fill up and block its input.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req  = 0;
        held_once = 1'b1;
        out_bus.ready <= 1'b1;
      end else if (snk_throttle && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [PIX_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly inside the image, sometimes just past its far edge where taps still
  // reach back in, sometimes anywhere in the coordinate range.
  function automatic int pick_coord(int size, int half);
    int sel;
    int reach;
    sel   = $urandom_range(0, 9);
    reach = (size - 1 + half > 255) ? 255 : size - 1 + half;
    if (sel < 7) return $urandom_range(0, size - 1);
    if (sel < 9) return $urandom_range(0, reach);
    return $urandom_range(0, 255);
  endfunction

  // Offers one transaction and returns at the edge where it was accepted.
  task automatic push_item(logic [OP_W-1:0] op, logic [XY_W-1:0] c, logic [XY_W-1:0] r,
                           logic signed [PIX_W-1:0] v);
    if (src_throttle && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.col       <= c;
    in_bus.row       <= r;
    in_bus.value     <= v;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sent_items++;
    if (op == OP_WRITE_PIXEL) begin
      pix_set[int'(r) * MAX_WIDTH + int'(c)] = 1'b1;
    end else if (op == OP_WRITE_COEF && c < MAX_KW && r < MAX_KH) begin
      coef_set[int'(r) * MAX_KW + int'(c)] = 1'b1;
    end
  endtask

  // Fills every pixel and coefficient that the compute will read and that is
  // still unwritten, then issues the compute itself.
  task automatic send_compute(int x, int y);
    int w, h, hw, hh, sx, sy;
    chk.window(w, h, hw, hh);
    for (int j = -hh; j <= hh; j++) begin
      for (int i = -hw; i <= hw; i++) begin
        sx = x - i;
        sy = y - j;
        if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
          if (!pix_set[sy * MAX_WIDTH + sx])
            push_item(OP_WRITE_PIXEL, 8'(sx), 8'(sy), pick_value());
          if (!coef_set[(j + hh) * MAX_KW + (i + hw)])
            push_item(OP_WRITE_COEF, 8'(i + hw), 8'(j + hh), pick_value());
        end
      end
    end
    push_item(OP_COMPUTE, 8'(x), 8'(y), 16'($urandom()));
  endtask

  // Stops offering and waits until every expected output has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (chk.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register with junk above its width, then reads it back.
  task automatic program_reg(reg_idx_e idx, int unsigned raw);
    logic [APB_DW-1:0] mask;
    logic [APB_DW-1:0] word;
    mask = (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) ?
           (32'd1 << DIM_W) - 1 : (32'd1 << KDIM_W) - 1;
    word = (raw & mask) | ($urandom() & ~mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chk.set_register(idx, word);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (word & mask)) begin
      $error("register %s: expected %0d, actual %0d", idx.name(), word & mask, prdata);
      chk.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sizes(int unsigned w, int unsigned h, int unsigned kw,
                           int unsigned kh);
    program_reg(REG_IMAGE_WIDTH, w);
    program_reg(REG_IMAGE_HEIGHT, h);
    program_reg(REG_KERNEL_WIDTH, kw);
    program_reg(REG_KERNEL_HEIGHT, kh);
    @(posedge clk_i);
  endtask

  // One random transaction. Computes dominate because they are the only ones
  // that exercise the datapath; the rest overwrite data or are plain noise.
  task automatic random_item();
    int w, h, hw, hh;
    int pick;
    chk.window(w, h, hw, hh);
    pick = $urandom_range(0, 39);
    if (pick < 20) begin
      send_compute(pick_coord(w, hw), pick_coord(h, hh));
    end else if (pick < 27) begin
      if ($urandom_range(0, 3) == 0)
        push_item(OP_WRITE_PIXEL, 8'($urandom()), 8'($urandom()), pick_value());
      else
        push_item(OP_WRITE_PIXEL, 8'($urandom_range(0, w - 1)),
                  8'($urandom_range(0, h - 1)), pick_value());
    end else if (pick < 33) begin
      push_item(OP_WRITE_COEF, 8'($urandom_range(0, MAX_KW - 1)),
                8'($urandom_range(0, MAX_KH - 1)), pick_value());
    end else if (pick < 35) begin
      push_item(OP_UNUSED, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    end else if (pick < 37) begin
      // Coefficient write past the kernel store: must be dropped.
      if ($urandom_range(0, 1) == 0)
        push_item(OP_WRITE_COEF, 8'($urandom_range(MAX_KW, 255)), 8'($urandom()),
                  16'($urandom()));
      else
        push_item(OP_WRITE_COEF, 8'($urandom()), 8'($urandom_range(MAX_KH, 255)),
                  16'($urandom()));
    end else if (pick < 39) begin
      send_compute(pick_coord(w, hw), pick_coord(h, hh));
    end else begin
      // Let the pipe run dry in the middle of a phase.
      wait_drained();
    end
  endtask

  initial begin
    int start;
    int target;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = '0;
    in_bus.col       = '0;
    in_bus.row       = '0;
    in_bus.value     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    src_throttle     = 1'b1;
    snk_throttle     = 1'b1;
    hold_req         = 0;
    held_once        = 1'b0;
    sent_items       = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset sizes (256 by 256 image, 3 by 3 kernel):
    // unused operation, coefficient writes off the kernel store, extreme
    // values, and computes at both image corners and inside.
    push_item(OP_UNUSED, 8'd255, 8'd255, 16'sh8000);
    push_item(OP_UNUSED, 8'd0, 8'd0, 16'sh7fff);
    push_item(OP_WRITE_COEF, 8'd7, 8'd0, 16'sh7fff);
    push_item(OP_WRITE_COEF, 8'd0, 8'd255, 16'sh8000);
    push_item(OP_WRITE_COEF, 8'd255, 8'd255, 16'shffff);
    push_item(OP_WRITE_COEF, 8'd0, 8'd0, 16'sh8000);
    push_item(OP_WRITE_COEF, 8'd1, 8'd1, 16'sh7fff);
    push_item(OP_WRITE_COEF, 8'd2, 8'd2, 16'sh4000);
    push_item(OP_WRITE_PIXEL, 8'd0, 8'd0, 16'sh7fff);
    push_item(OP_WRITE_PIXEL, 8'd1, 8'd0, 16'sh8000);
    push_item(OP_WRITE_PIXEL, 8'd0, 8'd1, 16'sh8000);
    push_item(OP_WRITE_PIXEL, 8'd1, 8'd1, 16'sh7fff);
    push_item(OP_WRITE_PIXEL, 8'd255, 8'd255, 16'sh8000);
    push_item(OP_WRITE_PIXEL, 8'd254, 8'd255, 16'sh7fff);
    send_compute(0, 0);
    send_compute(255, 255);
    send_compute(1, 1);
    send_compute(128, 64);
    wait_drained();

    // Random phases, each under its own size setting. The first ones hit the
    // register extremes: smallest sizes, largest sizes, zero (clamped up),
    // over-range and even kernel sizes.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      target = 130;
      case (phase)
        0: set_sizes(1, 1, 1, 1);
        1: begin
          set_sizes(256, 256, 7, 7);
          target = 60;
        end
        2: set_sizes(0, 0, 0, 0);
        3: begin
          set_sizes(511, 300, 6, 4);
          target = 60;
        end
        4: set_sizes(8, 5, 7, 2);
        5: set_sizes(16, 16, 7, 7);
        default: set_sizes($urandom_range(1, 32), $urandom_range(1, 32),
                           $urandom_range(0, 7), $urandom_range(0, 7));
      endcase
      // Throttling on some phases, none at all in the last two.
      src_throttle = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      snk_throttle = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (phase == 5) hold_req = LONG_HOLD;
      start = sent_items;
      while (sent_items - start < target) random_item();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (chk.pending() != 0) begin
      $error("%0d expected results never arrived", chk.pending());
      chk.errors++;
    end

    $display("Run covered %0d transactions, %0d computes and %0d checked outputs",
             sent_items, chk.computes_seen, chk.outputs_seen);
    $display("over %0d size settings; long output hold-off applied: %0b",
             NUM_PHASES + 1, held_once);
    if (chk.errors == 0)
      $display("** image_convolution_2d: PASSED **");
    else
      $display("** image_convolution_2d: FAILED **");
    $finish;
  end

endmodule
